/* hdl/mphd_pkg.sv */
// ----------------------------------------------------------------------------
// mphd_pkg
// Shared constants and codes for the mesh packet header deframer.
// ----------------------------------------------------------------------------
package mphd_pkg;

   // address field size in bytes and saturating packet length
   localparam int ADDRESS_BYTES    = 16;
   localparam int MAX_PACKET_BYTES = 1023;

   // byte position counter width, plus one bit of headroom for compares
   localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);
   localparam int CMP_W = POS_W + 1;

   // flag byte masks
   localparam logic [7:0] FLAG_HEADER_MASK = 8'b0100_0000;
   localparam logic [7:0] FLAG_PROP_MASK   = 8'b0011_0000;
   localparam logic [7:0] FLAG_DEST_MASK   = 8'b0000_1100;
   localparam logic [7:0] FLAG_PKT_MASK    = 8'b0000_0011;
   localparam logic [7:0] HASH_FLAG_MASK   = 8'b0000_1111;

   localparam int FLAG_PROP_SHIFT = 4;
   localparam int FLAG_DEST_SHIFT = 2;

   // field kind codes
   localparam logic [2:0] KIND_FLAGS     = 3'd0;
   localparam logic [2:0] KIND_HOPS      = 3'd1;
   localparam logic [2:0] KIND_TRANSPORT = 3'd2;
   localparam logic [2:0] KIND_DEST      = 3'd3;
   localparam logic [2:0] KIND_CONTEXT   = 3'd4;
   localparam logic [2:0] KIND_DATA      = 3'd5;

endpackage

/* hdl/mesh_packet_header_deframer_top.sv */
// ----------------------------------------------------------------------------
// mesh_packet_header_deframer_top
// Tags each received packet byte with its header field and builds the
// hashable-part byte stream.
// ----------------------------------------------------------------------------
// One beat in, one beat out: every input byte produces exactly one result in
// the next cycle, and a byte can be taken every cycle while results drain. The
// only loop is the byte position counter and the captured flag and hop bytes,
// updated in the cycle a byte is taken; the result sits in an output register,
// so a new byte is taken whenever that register is empty or being drained.
// The flag byte decodes the header, propagation, destination and packet kinds;
// a beat with the last-byte mark closes the packet, reports too-short status
// and restarts the counter for the next packet.
module mesh_packet_header_deframer_top
   import mphd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_byte_in,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_field_kind,
   output logic [7:0] rsp_byte_out,
   output logic [3:0] rsp_field_offset,
   output logic       rsp_hash_valid,
   output logic [7:0] rsp_hash_byte,
   output logic       rsp_header_kind,
   output logic [1:0] rsp_propagation_kind,
   output logic [1:0] rsp_destination_kind,
   output logic [1:0] rsp_packet_kind,
   output logic [7:0] rsp_hop_count,
   output logic       rsp_packet_done,
   output logic       rsp_frame_status
);

   localparam logic [CMP_W-1:0] ADDR1_END = CMP_W'(2 + ADDRESS_BYTES);
   localparam logic [CMP_W-1:0] ADDR2_END = CMP_W'(2 + 2 * ADDRESS_BYTES);
   localparam logic [CMP_W-1:0] MIN_ONE   = CMP_W'(3 + ADDRESS_BYTES);
   localparam logic [CMP_W-1:0] MIN_TWO   = CMP_W'(3 + 2 * ADDRESS_BYTES);
   localparam logic [POS_W-1:0] POS_MAX   = POS_W'(MAX_PACKET_BYTES);
   localparam logic [POS_W-1:0] OFS_ONE   = POS_W'(2);
   localparam logic [POS_W-1:0] OFS_TWO   = POS_W'(2 + ADDRESS_BYTES);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       flag_ff, flag_in;
   logic [7:0]       hops_ff, hops_in;

   logic             rsp_valid_ff;
   logic [2:0]       kind_ff, kind_in;
   logic [7:0]       byte_ff;
   logic [3:0]       offset_ff, offset_in;
   logic             hvalid_ff, hvalid_in;
   logic [7:0]       hbyte_ff, hbyte_in;
   logic             two_ff, two_in;
   logic [1:0]       prop_ff, dest_ff, pkt_ff;
   logic [7:0]       hopc_ff, hopc_in;
   logic             done_ff;
   logic             status_ff, status_in;

   logic             accept;
   logic [CMP_W-1:0] pos_ext;
   logic [7:0]       fl;
   logic             first, second;
   logic [POS_W-1:0] offset_full;
   logic [7:0]       prop_bits, dest_bits;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign pos_ext = {1'b0, pos_ff};
   assign first   = (pos_ff == '0);
   assign second  = (pos_ff == POS_W'(1));
   assign fl      = first ? req_byte_in : flag_ff;
   assign two_in  = |(fl & FLAG_HEADER_MASK);

   assign prop_bits = (fl & FLAG_PROP_MASK) >> FLAG_PROP_SHIFT;
   assign dest_bits = (fl & FLAG_DEST_MASK) >> FLAG_DEST_SHIFT;

   always_comb begin
      kind_in     = KIND_DATA;
      offset_full = '0;
      if (first) begin
         kind_in = KIND_FLAGS;
      end else if (second) begin
         kind_in = KIND_HOPS;
      end else if (two_in) begin
         if (pos_ext < ADDR1_END) begin
            kind_in     = KIND_TRANSPORT;
            offset_full = pos_ff - OFS_ONE;
         end else if (pos_ext < ADDR2_END) begin
            kind_in     = KIND_DEST;
            offset_full = pos_ff - OFS_TWO;
         end else if (pos_ext == ADDR2_END) begin
            kind_in = KIND_CONTEXT;
         end
      end else begin
         if (pos_ext < ADDR1_END) begin
            kind_in     = KIND_DEST;
            offset_full = pos_ff - OFS_ONE;
         end else if (pos_ext == ADDR1_END) begin
            kind_in = KIND_CONTEXT;
         end
      end
   end

   assign offset_in = offset_full[3:0];

   always_comb begin
      hvalid_in = 1'b0;
      hbyte_in  = '0;
      if (first) begin
         hvalid_in = 1'b1;
         hbyte_in  = req_byte_in & HASH_FLAG_MASK;
      end else if (two_in ? (pos_ext >= ADDR1_END) : !second) begin
         hvalid_in = 1'b1;
         hbyte_in  = req_byte_in;
      end
   end

   assign hopc_in = first ? 8'd0 : (second ? req_byte_in : hops_ff);

   // length is position plus one
   assign status_in = req_last_byte &&
                      ((pos_ext + CMP_W'(1)) < (two_in ? MIN_TWO : MIN_ONE));

   always_comb begin
      pos_in  = pos_ff;
      flag_in = flag_ff;
      hops_in = hops_ff;
      if (accept) begin
         if (req_last_byte) begin
            pos_in  = '0;
            flag_in = '0;
            hops_in = '0;
         end else begin
            if (first)  flag_in = req_byte_in;
            if (second) hops_in = req_byte_in;
            if (pos_ff < POS_MAX) pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         flag_ff      <= '0;
         hops_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         flag_ff <= flag_in;
         hops_ff <= hops_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result beat payload
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff   <= kind_in;
         byte_ff   <= req_byte_in;
         offset_ff <= offset_in;
         hvalid_ff <= hvalid_in;
         hbyte_ff  <= hbyte_in;
         two_ff    <= two_in;
         prop_ff   <= prop_bits[1:0];
         dest_ff   <= dest_bits[1:0];
         pkt_ff    <= fl[1:0] & FLAG_PKT_MASK[1:0];
         hopc_ff   <= hopc_in;
         done_ff   <= req_last_byte;
         status_ff <= status_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_field_kind       = kind_ff;
   assign rsp_byte_out         = byte_ff;
   assign rsp_field_offset     = offset_ff;
   assign rsp_hash_valid       = hvalid_ff;
   assign rsp_hash_byte        = hbyte_ff;
   assign rsp_header_kind      = two_ff;
   assign rsp_propagation_kind = prop_ff;
   assign rsp_destination_kind = dest_ff;
   assign rsp_packet_kind      = pkt_ff;
   assign rsp_hop_count        = hopc_ff;
   assign rsp_packet_done      = done_ff;
   assign rsp_frame_status     = status_ff;

endmodule
